// ----- sv/four_bit_palette_blitter_macros.svh -----
// ---------------------------------------------------------------------------
// four_bit_palette_blitter assertion macros
// Immediate-implication and next-cycle-implication property wrappers.
// ---------------------------------------------------------------------------
`ifndef FOUR_BIT_PALETTE_BLITTER_MACROS_SVH
`define FOUR_BIT_PALETTE_BLITTER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define FBPB_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fbpb assertion failed");
`define FBPB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fbpb assertion failed");
`else
`define FBPB_ASSERT_IMPL(lbl, ante, cons)
`define FBPB_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- sv/fbpb_pkg.sv -----
// ---------------------------------------------------------------------------
// fbpb_pkg
// Shared types and constants of the 4bpp palette blitter.
// ---------------------------------------------------------------------------
`default_nettype none

package fbpb_pkg;

	localparam int PALETTE_PAIRS  = 256;
	localparam int PAL_INDEX_BITS = $clog2(PALETTE_PAIRS);
	localparam int ADDRESS_BITS   = 24;
	localparam int DEST_ADDR_BITS = 24;
	localparam int LANES          = 4;
	localparam int PIXELS         = 2 * LANES;
	localparam int PIX_IDX_BITS   = $clog2(PIXELS);
	localparam int CFG_DATA_BITS  = 13;
	localparam int CFG_INDEX_BITS = 3;
	localparam int COL_BITS       = 9;
	localparam int ROW_BITS       = 12;
	localparam int PROD_BITS      = 25;

	localparam logic [7:0]              BYTE_MASK  = 8'hFF;
	localparam logic [PIX_IDX_BITS-1:0] LAST_PIXEL = 3'd7;
	localparam logic [COL_BITS:0]       MAX_GROUPS = 10'd512;
	localparam logic [ROW_BITS:0]       MAX_ROWS   = 13'd4096;

	typedef logic [ADDRESS_BITS-1:0] addr_t;

	typedef enum logic [1:0] {
		MODE_EXPAND        = 2'd0,
		MODE_EXPAND_NOMASK = 2'd1,
		MODE_COPY          = 2'd2,
		MODE_MASKED        = 2'd3
	} mode_t;

	typedef enum logic {
		CMD_PAL_WRITE = 1'b0,
		CMD_SOURCE    = 1'b1
	} cmd_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_MODE        = 3'd0,
		REG_DEST_X      = 3'd1,
		REG_DEST_Y      = 3'd2,
		REG_DEST_PITCH  = 3'd3,
		REG_RECT_WIDTH  = 3'd4,
		REG_RECT_HEIGHT = 3'd5
	} reg_idx_t;

	typedef struct packed {
		mode_t       mode;
		logic [11:0] dest_x;
		logic [11:0] dest_y;
		logic [12:0] dest_pitch;
		logic [12:0] rect_width;
		logic [12:0] rect_height;
	} cfg_t;

	typedef struct packed {
		logic                first;
		logic                wrap;
		logic                rend;
		logic                expand;
		logic [COL_BITS-1:0] col;
	} pos_t;

	typedef struct packed {
		addr_t       addr;
		logic        expand;
		logic        rend;
		logic [31:0] word;
	} item_t;

	function automatic logic is_expand(mode_t m);
		return (m == MODE_EXPAND) || (m == MODE_EXPAND_NOMASK);
	endfunction

endpackage

`default_nettype wire

// ----- sv/fbpb_lane.sv -----
// ---------------------------------------------------------------------------
// fbpb_lane
// One expansion lane: private copy of the palette with a registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module fbpb_lane (
	input  wire logic                               clk,
	input  wire logic                               wr_en,
	input  wire logic [fbpb_pkg::PAL_INDEX_BITS-1:0] wr_index,
	input  wire logic [63:0]                        wr_pair,
	input  wire logic                               rd_en,
	input  wire logic [fbpb_pkg::PAL_INDEX_BITS-1:0] rd_index,
	output logic      [63:0]                        rd_pair
);
	import fbpb_pkg::*;

	logic [63:0] mem [PALETTE_PAIRS];
	logic [63:0] rd_pair_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_index] <= wr_pair;
		end
		if (rd_en) begin
			rd_pair_q <= mem[rd_index];
		end
	end

	assign rd_pair = rd_pair_q;

endmodule

`default_nettype wire

// ----- sv/fbpb_walk.sv -----
// ---------------------------------------------------------------------------
// fbpb_walk
// Rectangle walker: group/row counters at accept, row base and word address
// for the item in stage 1.
// ---------------------------------------------------------------------------
`default_nettype none

module fbpb_walk (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire fbpb_pkg::cfg_t  cfg,
	input  wire logic            step,
	output fbpb_pkg::pos_t       pos,
	input  wire logic            commit,
	input  wire fbpb_pkg::pos_t  pos_s1,
	output fbpb_pkg::addr_t      addr0
);
	import fbpb_pkg::*;

	logic [COL_BITS-1:0]  col_q;
	logic [ROW_BITS-1:0]  row_q;
	addr_t                row_base_q;
	logic [PROD_BITS-1:0] prod_q;

	logic [COL_BITS:0]    groups_raw, groups, col_inc;
	logic [ROW_BITS:0]    rows, row_inc;
	logic                 wrap, last_row;
	logic [PROD_BITS-1:0] sum4;
	addr_t                start, base, offset, step_amt, rb_next;

	always_comb begin
		groups_raw = cfg.rect_width[12:3];
		if (groups_raw == '0) begin
			groups = 10'd1;
		end else if (groups_raw > MAX_GROUPS) begin
			groups = MAX_GROUPS;
		end else begin
			groups = groups_raw;
		end
		if (cfg.rect_height == '0) begin
			rows = 13'd1;
		end else if (cfg.rect_height > MAX_ROWS) begin
			rows = MAX_ROWS;
		end else begin
			rows = cfg.rect_height;
		end
		col_inc    = {1'b0, col_q} + 10'd1;
		row_inc    = {1'b0, row_q} + 13'd1;
		wrap       = col_inc >= groups;
		last_row   = row_inc >= rows;
		pos.first  = (col_q == '0) && (row_q == '0);
		pos.wrap   = wrap;
		pos.rend   = wrap && last_row;
		pos.expand = is_expand(cfg.mode);
		pos.col    = col_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (step) begin
			col_q <= wrap ? '0 : col_inc[COL_BITS-1:0];
			if (wrap) begin
				row_q <= last_row ? '0 : row_inc[ROW_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= PROD_BITS'(cfg.dest_y) * PROD_BITS'(cfg.dest_pitch);
	end

	always_comb begin
		sum4 = PROD_BITS'(prod_q[PROD_BITS-1:1]) + PROD_BITS'(cfg.dest_x[11:1]);
		if (pos_s1.expand) begin
			start    = addr_t'(prod_q + PROD_BITS'(cfg.dest_x));
			offset   = addr_t'({pos_s1.col, 3'b000});
			step_amt = addr_t'(cfg.dest_pitch);
		end else begin
			start    = addr_t'(sum4 >> 2);
			offset   = addr_t'(pos_s1.col);
			step_amt = addr_t'(cfg.dest_pitch >> 3);
		end
		base    = pos_s1.first ? start : row_base_q;
		addr0   = addr_t'(base + offset);
		rb_next = pos_s1.wrap ? addr_t'(base + step_amt) : base;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_base_q <= '0;
		end else if (commit) begin
			row_base_q <= rb_next;
		end
	end

endmodule

`default_nettype wire

// ----- sv/fbpb_merge.sv -----
// ---------------------------------------------------------------------------
// fbpb_merge
// Output buffer: gathers the lane pixels of one item and sends them out one
// result per cycle while out_ready is high.
// ---------------------------------------------------------------------------
`default_nettype none

module fbpb_merge (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          load,
	input  wire fbpb_pkg::item_t               item,
	input  wire logic [fbpb_pkg::PIXELS-1:0][31:0] pix,
	output logic                               buf_free,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [fbpb_pkg::DEST_ADDR_BITS-1:0] dest_address,
	output logic [31:0]                        dest_data,
	output logic                               last,
	output logic                               rect_end
);
	import fbpb_pkg::*;

	logic                         valid_q;
	logic [PIX_IDX_BITS-1:0]      idx_q;
	item_t                        item_q;
	logic [PIXELS-1:0][31:0]      pix_q;
	logic                         last_elem;

	assign last_elem = !item_q.expand || (idx_q == LAST_PIXEL);
	assign buf_free  = !valid_q || (out_ready && last_elem);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (valid_q && out_ready) begin
			if (last_elem) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_q <= item;
			pix_q  <= pix;
		end
	end

	always_comb begin
		out_valid = valid_q;
		if (item_q.expand) begin
			dest_address = DEST_ADDR_BITS'(item_q.addr + addr_t'(idx_q));
			dest_data    = pix_q[idx_q];
		end else begin
			dest_address = DEST_ADDR_BITS'(item_q.addr);
			dest_data    = item_q.word;
		end
		last     = last_elem;
		rect_end = last_elem && item_q.rend;
	end

endmodule

`default_nettype wire

// ----- sv/four_bit_palette_blitter.sv -----
// ---------------------------------------------------------------------------
// four_bit_palette_blitter
// Write side of a 4bpp rectangle blitter with palette-pair expansion.
// ---------------------------------------------------------------------------
// Input channel (in_valid/in_ready): command 0 writes a palette pair into all
// four lane copies of the palette and gives no result.
// Command 1 carries one source word of eight pixels.
// Output channel (out_valid/out_ready): one destination word per transfer.
// Expand modes give eight results per source word, one per cycle while
// out_ready is high; copy and masked modes give one result and run at
// 1 item per cycle while out_ready is high.
// After the input transfer, stage 1 does the palette read and address add,
// then the output buffer loads and presents the first result.
// The next item is taken while the buffer still drains; stage 1 holds one
// item waiting, so in_ready drops only when both are full.
// A stalled receiver holds the current result and backs up into stage 1.
// Reset clears the walk (first item restarts the rectangle), pipeline valid
// bits and registers to defaults, not the palette. Registers are written
// by the user through cfg_we/cfg_index/cfg_data only while idle; unenforced.
// ---------------------------------------------------------------------------
`default_nettype none

`include "four_bit_palette_blitter_macros.svh"

module four_bit_palette_blitter (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [fbpb_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [fbpb_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic                                command,
	input  wire logic [7:0]                          pal_index,
	input  wire logic [63:0]                         pal_pair,
	input  wire logic [31:0]                         src_word,
	input  wire logic [31:0]                         mask_word,
	input  wire logic [31:0]                         old_dest_word,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [fbpb_pkg::DEST_ADDR_BITS-1:0]      dest_address,
	output logic [31:0]                              dest_data,
	output logic                                     last,
	output logic                                     rect_end
);
	import fbpb_pkg::*;

	cfg_t  cfg_q;
	logic  in_xfer, src_xfer, pal_wr, load, buf_free;
	logic  valid_s1;
	pos_t  pos, pos_s1;
	logic  [31:0] word_s1, word;
	addr_t addr0;
	item_t item;
	logic  [LANES-1:0][63:0] pair;
	logic  [PIXELS-1:0][31:0] pix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode        <= MODE_EXPAND;
			cfg_q.dest_x      <= '0;
			cfg_q.dest_y      <= '0;
			cfg_q.dest_pitch  <= 13'd8;
			cfg_q.rect_width  <= 13'd8;
			cfg_q.rect_height <= 13'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:        cfg_q.mode        <= mode_t'(cfg_data[1:0]);
				REG_DEST_X:      cfg_q.dest_x      <= cfg_data[11:0];
				REG_DEST_Y:      cfg_q.dest_y      <= cfg_data[11:0];
				REG_DEST_PITCH:  cfg_q.dest_pitch  <= cfg_data;
				REG_RECT_WIDTH:  cfg_q.rect_width  <= cfg_data;
				REG_RECT_HEIGHT: cfg_q.rect_height <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_ready = !valid_s1 || buf_free;
	assign in_xfer  = in_valid && in_ready;
	assign src_xfer = in_xfer && (cmd_t'(command) == CMD_SOURCE);
	assign pal_wr   = in_xfer && (cmd_t'(command) == CMD_PAL_WRITE);
	assign load     = valid_s1 && buf_free;

	assign word = (cfg_q.mode == MODE_MASKED) ? ((old_dest_word & mask_word) ^ src_word)
	                                          : src_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src_xfer) begin
			valid_s1 <= 1'b1;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (src_xfer) begin
			pos_s1  <= pos;
			word_s1 <= word;
		end
	end

	fbpb_walk u_walk (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.step   (src_xfer),
		.pos    (pos),
		.commit (load),
		.pos_s1 (pos_s1),
		.addr0  (addr0)
	);

	for (genvar k = 0; k < LANES; k++) begin : g_lane
		fbpb_lane u_lane (
			.clk      (clk),
			.wr_en    (pal_wr),
			.wr_index (pal_index),
			.wr_pair  (pal_pair),
			.rd_en    (src_xfer),
			.rd_index (8'(src_word >> (8 * k)) & BYTE_MASK),
			.rd_pair  (pair[k])
		);
		assign pix[2*k]   = pair[k][31:0];
		assign pix[2*k+1] = pair[k][63:32];
	end

	always_comb begin
		item.addr   = addr0;
		item.expand = pos_s1.expand;
		item.rend   = pos_s1.rend;
		item.word   = word_s1;
	end

	fbpb_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (load),
		.item         (item),
		.pix          (pix),
		.buf_free     (buf_free),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.dest_address (dest_address),
		.dest_data    (dest_data),
		.last         (last),
		.rect_end     (rect_end)
	);

	`FBPB_ASSERT_NEXT(a_s1_hold, valid_s1 && !buf_free, valid_s1)
	`FBPB_ASSERT_NEXT(a_burst_continues, out_valid && out_ready && !last, out_valid)
	`FBPB_ASSERT_IMPL(a_end_on_last, out_valid && rect_end, last)

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for four_bit_palette_blitter. It loads palette pairs,
// streams source words through every mode and varied register settings, with
// random sender gaps and receiver stalls, predicts each destination write and
// compares every output transfer field by field in order.
// ---------------------------------------------------------------------------
module tb;
	import fbpb_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int SETTLE_CYCLES  = 6;
	localparam int RANDOM_PHASES  = 6;
	localparam int PHASE_ITEMS    = 22;
	localparam int TAIL_ITEMS     = 25;
	localparam logic [CFG_INDEX_BITS-1:0] SPARE_REG_LO = 3'd6;
	localparam logic [CFG_INDEX_BITS-1:0] SPARE_REG_HI = 3'd7;

	typedef struct packed {
		addr_t       addr;
		logic [31:0] data;
		logic        last;
		logic        rend;
	} dest_write_t;

	logic                      clk           = 1'b0;
	logic                      arst_n        = 1'b0;
	logic                      cfg_we        = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index     = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data      = '0;
	logic                      in_valid      = 1'b0;
	logic                      in_ready;
	logic                      command       = 1'b0;
	logic [7:0]                pal_index     = '0;
	logic [63:0]               pal_pair      = '0;
	logic [31:0]               src_word      = '0;
	logic [31:0]               mask_word     = '0;
	logic [31:0]               old_dest_word = '0;
	logic                      out_valid;
	logic                      out_ready     = 1'b1;
	logic [DEST_ADDR_BITS-1:0] dest_address;
	logic [31:0]               dest_data;
	logic                      last;
	logic                      rect_end;

	cfg_t        cfg_shadow;
	logic [63:0] pal_shadow [PALETTE_PAIRS];
	bit          pal_loaded [PALETTE_PAIRS];
	logic [7:0]  loaded_idx [$];
	int unsigned walk_col;
	int unsigned walk_row;
	addr_t       walk_base;
	dest_write_t writes_due [$];
	dest_write_t due_head;
	int          errors;
	bit          sender_gaps;
	bit          sink_stalls;
	int          sink_hold;
	int          quiet_cycles;

	four_bit_palette_blitter dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.pal_index     (pal_index),
		.pal_pair      (pal_pair),
		.src_word      (src_word),
		.mask_word     (mask_word),
		.old_dest_word (old_dest_word),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.dest_address  (dest_address),
		.dest_data     (dest_data),
		.last          (last),
		.rect_end      (rect_end)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic bit wide_mode();
		return cfg_shadow.mode == MODE_EXPAND || cfg_shadow.mode == MODE_EXPAND_NOMASK;
	endfunction

	function automatic addr_t rect_origin();
		logic [31:0] lin;
		lin = cfg_shadow.dest_y * cfg_shadow.dest_pitch;
		if (wide_mode())
			return addr_t'(lin + cfg_shadow.dest_x);
		return addr_t'(((lin >> 1) + (cfg_shadow.dest_x >> 1)) >> 2);
	endfunction

	function automatic void note_palette(logic [7:0] idx, logic [63:0] pair);
		pal_shadow[idx] = pair;
		if (!pal_loaded[idx]) begin
			pal_loaded[idx] = 1'b1;
			loaded_idx.push_back(idx);
		end
	endfunction

	function automatic void predict_dest_writes(logic [31:0] src, logic [31:0] mask,
			logic [31:0] old);
		int unsigned groups;
		int unsigned rows;
		logic        rect_done;
		logic [63:0] pair;
		dest_write_t w;
		groups = cfg_shadow.rect_width >> 3;
		if (groups < 1)
			groups = 1;
		if (groups > MAX_GROUPS)
			groups = MAX_GROUPS;
		rows = cfg_shadow.rect_height;
		if (rows < 1)
			rows = 1;
		if (rows > MAX_ROWS)
			rows = MAX_ROWS;
		if (walk_col == 0 && walk_row == 0)
			walk_base = rect_origin();
		rect_done = (walk_col + 1 >= groups) && (walk_row + 1 >= rows);
		if (wide_mode()) begin
			for (int k = 0; k < PIXELS; k++) begin
				pair   = pal_shadow[src[(k / 2) * 8 +: 8]];
				w.addr = addr_t'(walk_base + walk_col * PIXELS + k);
				w.data = (k % 2) ? pair[63:32] : pair[31:0];
				w.last = (k == PIXELS - 1);
				w.rend = w.last && rect_done;
				writes_due.push_back(w);
			end
		end else begin
			w.addr = addr_t'(walk_base + walk_col);
			w.data = (cfg_shadow.mode == MODE_MASKED) ? ((old & mask) ^ src) : src;
			w.last = 1'b1;
			w.rend = rect_done;
			writes_due.push_back(w);
		end
		walk_col++;
		if (walk_col >= groups) begin
			walk_col  = 0;
			walk_base = addr_t'(walk_base + (wide_mode() ? cfg_shadow.dest_pitch
				: cfg_shadow.dest_pitch >> 3));
			walk_row++;
			if (walk_row >= rows)
				walk_row = 0;
		end
	endfunction

	// in expand modes every byte must hit a loaded palette entry
	function automatic logic [31:0] pick_source();
		logic [31:0] word;
		word = $urandom;
		if (wide_mode())
			for (int b = 0; b < LANES; b++)
				word[b * 8 +: 8] = loaded_idx[$urandom_range(0, loaded_idx.size() - 1)];
		return word;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (writes_due.size() == 0) begin
				$display("%0t: unexpected transfer, expected none actual addr %h data %h",
					$time, dest_address, dest_data);
				errors++;
			end else begin
				due_head = writes_due.pop_front();
				check_field("dest_address", due_head.addr, dest_address);
				check_field("dest_data", due_head.data, dest_data);
				check_field("last", due_head.last, last);
				check_field("rect_end", due_head.rend, rect_end);
			end
		end
	end

	always @(negedge clk) begin
		if (sink_hold > 0) begin
			sink_hold <= sink_hold - 1;
			out_ready <= 1'b0;
		end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
			sink_hold <= $urandom_range(0, 11);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired", $time);
			$display("FAIL");
			$finish;
		end
	end

	task automatic send_item(cmd_t cmd, logic [7:0] idx, logic [63:0] pair,
			logic [31:0] src, logic [31:0] mask, logic [31:0] old);
		int gap;
		gap = (sender_gaps && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid      <= 1'b1;
		command       <= cmd;
		pal_index     <= idx;
		pal_pair      <= pair;
		src_word      <= src;
		mask_word     <= mask;
		old_dest_word <= old;
		do @(posedge clk); while (!in_ready);
		if (cmd == CMD_PAL_WRITE)
			note_palette(idx, pair);
		else
			predict_dest_writes(src, mask, old);
	endtask

	task automatic load_palette(logic [7:0] idx, logic [63:0] pair);
		send_item(CMD_PAL_WRITE, idx, pair, $urandom, $urandom, $urandom);
	endtask

	task automatic send_pixels(logic [31:0] src, logic [31:0] mask, logic [31:0] old);
		send_item(CMD_SOURCE, 8'($urandom), {$urandom, $urandom}, src, mask, old);
	endtask

	// drop valid, wait for every expected write, then let the pipe empty
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (writes_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		case (idx)
			REG_MODE:        cfg_shadow.mode        = mode_t'(value[1:0]);
			REG_DEST_X:      cfg_shadow.dest_x      = value[11:0];
			REG_DEST_Y:      cfg_shadow.dest_y      = value[11:0];
			REG_DEST_PITCH:  cfg_shadow.dest_pitch  = value;
			REG_RECT_WIDTH:  cfg_shadow.rect_width  = value;
			REG_RECT_HEIGHT: cfg_shadow.rect_height = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic configure(mode_t m, logic [11:0] x, logic [11:0] y, logic [12:0] pitch,
			logic [12:0] width, logic [12:0] height);
		settle();
		write_reg(REG_MODE, 13'(m));
		write_reg(REG_DEST_X, 13'(x));
		write_reg(REG_DEST_Y, 13'(y));
		write_reg(REG_DEST_PITCH, pitch);
		write_reg(REG_RECT_WIDTH, width);
		write_reg(REG_RECT_HEIGHT, height);
	endtask

	task automatic random_setup();
		mode_t       m;
		logic [12:0] pitch;
		logic [12:0] width;
		logic [12:0] height;
		m      = mode_t'($urandom_range(0, 3));
		pitch  = ($urandom_range(0, 7) == 0) ? 13'($urandom) : 13'($urandom_range(8, 4096));
		width  = ($urandom_range(0, 7) == 0) ? 13'($urandom) : 13'(8 * $urandom_range(1, 6));
		height = ($urandom_range(0, 7) == 0) ? 13'($urandom) : 13'($urandom_range(1, 4));
		configure(m, 12'($urandom), 12'($urandom), pitch, width, height);
	endtask

	task automatic random_item();
		if ($urandom_range(0, 3) == 0)
			load_palette(8'($urandom), {$urandom, $urandom});
		else
			send_pixels(pick_source(), $urandom, $urandom);
	endtask

	// registers still at reset values: 8x1 expand at origin
	task automatic test_reset_defaults();
		load_palette(8'h00, 64'h0);
		load_palette(8'hFF, '1);
		load_palette(8'h5A, 64'hAAAA_AAAA_5555_5555);
		load_palette(8'hA5, 64'h5555_5555_AAAA_AAAA);
		send_pixels(32'h0000_0000, $urandom, $urandom);
		send_pixels(32'hFFFF_FFFF, $urandom, $urandom);
		send_pixels(32'hA55A_00FF, $urandom, $urandom);
	endtask

	// origin at the top of the address space, pixel and row steps wrap
	task automatic test_expand_wrap();
		configure(MODE_EXPAND_NOMASK, 12'hFFF, 12'hFFF, 13'd4096, 13'd16, 13'd2);
		write_reg(SPARE_REG_LO, '1);
		write_reg(SPARE_REG_HI, 13'($urandom));
		send_pixels(pick_source(), '1, '0);
		send_pixels(pick_source(), '0, '1);
		send_pixels(pick_source(), '1, '1);
		send_pixels(pick_source(), '0, '0);
	endtask

	task automatic test_copy_masked();
		configure(MODE_COPY, 12'd0, 12'd0, 13'd16, 13'd16, 13'd2);
		send_pixels(32'h0000_0000, '1, '1);
		send_pixels(32'hFFFF_FFFF, '0, '0);
		send_pixels($urandom, $urandom, $urandom);
		send_pixels($urandom, $urandom, $urandom);
		// unaligned x, zero width and height clamp to one group, one row
		configure(MODE_MASKED, 12'hFFF, 12'hFFF, 13'h1FFF, 13'd0, 13'd0);
		send_pixels($urandom, '0, '1);
		send_pixels(32'h0000_0000, '1, '1);
		send_pixels(32'hFFFF_FFFF, '1, '0);
	endtask

	// walk keeps its row base across a mode change
	task automatic test_mid_rect();
		configure(MODE_EXPAND, 12'd8, 12'd3, 13'd64, 13'd16, 13'd2);
		send_pixels(pick_source(), $urandom, $urandom);
		send_pixels(pick_source(), $urandom, $urandom);
		configure(MODE_MASKED, 12'd16, 12'd1, 13'd40, 13'd16, 13'd2);
		repeat (3) send_pixels($urandom, $urandom, $urandom);
	endtask

	task automatic test_random();
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			sender_gaps = ($urandom_range(0, 2) != 0);
			sink_stalls = ($urandom_range(0, 2) != 0);
			random_setup();
			repeat (PHASE_ITEMS) random_item();
		end
	endtask

	task automatic test_quiet_tail();
		sender_gaps = 1'b0;
		sink_stalls = 1'b0;
		random_setup();
		repeat (TAIL_ITEMS) random_item();
	endtask

	initial begin
		cfg_shadow = '{mode: MODE_EXPAND, dest_x: 12'd0, dest_y: 12'd0,
			dest_pitch: 13'd8, rect_width: 13'd8, rect_height: 13'd1};
		sender_gaps = 1'b1;
		sink_stalls = 1'b1;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_expand_wrap();
		test_copy_masked();
		test_mid_rect();
		test_random();
		test_quiet_tail();
		settle();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
